>>> rtl/core/cbo_pkg.sv
// Shared constants, request codes and control structs for the circle/box overlap counter.
// No dependencies; used by cbo_cell, cbo_eval and circle_box_overlap_counter_core.
package cbo_pkg;

  localparam int ENTRIES_DEF    = 16;
  localparam int COORD_BITS_DEF = 16;

  localparam int          RAD_W           = 33;
  localparam logic [32:0] RADIUS_SQ_RESET = 33'd10000;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_CHECK = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

  typedef struct packed {
    logic valid;
    logic hit;
    logic busy;
  } eval_stat_t;

endpackage

>>> rtl/core/circle_box_overlap_counter_core.sv
// Circle/box overlap counter: ring of ENTRIES centre cells feeding one distance unit.
// Add, clear and unused requests go to the result state, which registers the result once the last is taken.
// Check: the sweep state rotates the ring through the distance unit, one centre per cycle,
// and the drain state waits for it to empty. Requests are taken only in the idle state.
// Reset (rst, synchronous): stored count 0, radius_squared 10000; centre cells are not cleared.
// Depends on cbo_pkg, cbo_cell and cbo_eval.
module circle_box_overlap_counter_core #(
  parameter int ENTRIES    = cbo_pkg::ENTRIES_DEF,
  parameter int COORD_BITS = cbo_pkg::COORD_BITS_DEF,
  parameter int CNT_W      = $clog2(ENTRIES + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [cbo_pkg::RAD_W-1:0]     cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    req_type,
  input  logic signed [COORD_BITS-1:0]  point_x,
  input  logic signed [COORD_BITS-1:0]  point_y,
  input  logic signed [COORD_BITS-1:0]  box_left,
  input  logic signed [COORD_BITS-1:0]  box_right,
  input  logic signed [COORD_BITS-1:0]  box_bottom,
  input  logic signed [COORD_BITS-1:0]  box_top,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [CNT_W-1:0]              hit_count,
  output logic                          accepted,
  output logic [CNT_W-1:0]              stored_count
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SWEEP  = 4'b0010,
    S_DRAIN  = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  state_t                       state;
  logic [cbo_pkg::RAD_W-1:0]    radius_sq;
  logic [CNT_W-1:0]             entry_count;
  logic [CNT_W-1:0]             step;
  logic [CNT_W-1:0]             hits;
  logic                         res_acc;
  logic signed [COORD_BITS-1:0] box_l, box_r, box_b, box_t;
  logic                         in_fire;
  logic                         sweeping;
  logic                         has_room;
  cbo_pkg::eval_stat_t          ev_stat;

  logic signed [COORD_BITS-1:0] cell_x [ENTRIES];
  logic signed [COORD_BITS-1:0] cell_y [ENTRIES];

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid & in_ready;
  assign sweeping = (state == S_SWEEP);
  assign has_room = (entry_count < CNT_W'(ENTRIES));

  // Ring rotates toward cell 0; after ENTRIES shifts every centre is back in place.
  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    localparam int NB = (i + 1) % ENTRIES;
    cbo_pkg::cell_ctrl_t ctrl;
    assign ctrl.shift = sweeping;
    assign ctrl.load  = in_fire && (req_type == cbo_pkg::REQ_ADD) && has_room
                        && (entry_count == CNT_W'(i));
    cbo_cell #(.COORD_BITS(COORD_BITS)) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .shift_x (cell_x[NB]),
      .shift_y (cell_y[NB]),
      .load_x  (point_x),
      .load_y  (point_y),
      .x       (cell_x[i]),
      .y       (cell_y[i])
    );
  end

  cbo_eval #(.COORD_BITS(COORD_BITS)) u_eval (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sweeping && (step < entry_count)),
    .cx        (cell_x[0]),
    .cy        (cell_y[0]),
    .box_l     (box_l),
    .box_r     (box_r),
    .box_b     (box_b),
    .box_t     (box_t),
    .radius_sq (radius_sq),
    .stat      (ev_stat)
  );

  always_ff @(posedge clk) begin
    if (in_fire && (req_type == cbo_pkg::REQ_CHECK)) begin
      box_l <= box_left;
      box_r <= box_right;
      box_b <= box_bottom;
      box_t <= box_top;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_sq <= cbo_pkg::RADIUS_SQ_RESET;
    end else if (cfg_wr_en) begin
      radius_sq <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      entry_count <= '0;
      step        <= '0;
      hits        <= '0;
      res_acc     <= 1'b0;
      out_valid   <= 1'b0;
      hit_count   <= '0;
      accepted    <= 1'b0;
      stored_count <= '0;
    end else begin
      // the result state handles its own output handshake
      if (out_valid && out_ready && (state != S_RESULT)) begin
        out_valid <= 1'b0;
      end
      if (ev_stat.valid && ev_stat.hit) begin
        hits <= hits + 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            hits <= '0;
            step <= '0;
            case (req_type)
              cbo_pkg::REQ_ADD: begin
                res_acc <= has_room;
                if (has_room) begin
                  entry_count <= entry_count + 1'b1;
                end
                state <= S_RESULT;
              end
              cbo_pkg::REQ_CHECK: begin
                res_acc <= 1'b1;
                state   <= S_SWEEP;
              end
              cbo_pkg::REQ_CLEAR: begin
                res_acc     <= 1'b1;
                entry_count <= '0;
                state       <= S_RESULT;
              end
              default: begin
                res_acc <= 1'b0;
                state   <= S_RESULT;
              end
            endcase
          end
        end
        S_SWEEP: begin
          step <= step + 1'b1;
          if (step == CNT_W'(ENTRIES - 1)) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!ev_stat.busy) begin
            state <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            hit_count    <= hits;
            accepted     <= res_acc;
            stored_count <= entry_count;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CNT_W'(ENTRIES))
    else $error("stored count above table size");

  a_hits_bounded: assert property (@(posedge clk) disable iff (rst)
    hits <= entry_count)
    else $error("hit count exceeds stored centres");

  a_idle_unit_empty: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !ev_stat.busy)
    else $error("distance unit busy while idle");

  a_sweep_holds: assert property (@(posedge clk) disable iff (rst)
    (state == S_SWEEP) && (step != CNT_W'(ENTRIES - 1)) |=> (state == S_SWEEP))
    else $error("sweep left before full rotation");

  a_add_grows: assert property (@(posedge clk) disable iff (rst)
    in_fire && (req_type == cbo_pkg::REQ_ADD) && has_room
    |=> entry_count == $past(entry_count) + 1'b1)
    else $error("add with room did not grow table");
`endif

endmodule

>>> rtl/core/cbo_cell.sv
// One cell of the centre ring: holds one stored centre, loads on add, rotates on sweep.
// Depends on cbo_pkg for the cell control struct.
module cbo_cell #(
  parameter int COORD_BITS = cbo_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  cbo_pkg::cell_ctrl_t           ctrl,
  input  logic signed [COORD_BITS-1:0]  shift_x,
  input  logic signed [COORD_BITS-1:0]  shift_y,
  input  logic signed [COORD_BITS-1:0]  load_x,
  input  logic signed [COORD_BITS-1:0]  load_y,
  output logic signed [COORD_BITS-1:0]  x,
  output logic signed [COORD_BITS-1:0]  y
);

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      x <= load_x;
      y <= load_y;
    end else if (ctrl.shift) begin
      x <= shift_x;
      y <= shift_y;
    end
  end

endmodule

>>> rtl/core/cbo_eval.sv
// Three-stage distance unit: clamp offset, square, sum and compare against the radius.
// Depends on cbo_pkg for the radius width and the status struct.
module cbo_eval #(
  parameter int COORD_BITS = cbo_pkg::COORD_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic signed [COORD_BITS-1:0]      cx,
  input  logic signed [COORD_BITS-1:0]      cy,
  input  logic signed [COORD_BITS-1:0]      box_l,
  input  logic signed [COORD_BITS-1:0]      box_r,
  input  logic signed [COORD_BITS-1:0]      box_b,
  input  logic signed [COORD_BITS-1:0]      box_t,
  input  logic [cbo_pkg::RAD_W-1:0]         radius_sq,
  output cbo_pkg::eval_stat_t               stat
);

  localparam int SQ_W  = 2 * COORD_BITS;
  localparam int SUM_W = SQ_W + 1;
  localparam int CMP_W = (SUM_W > cbo_pkg::RAD_W) ? SUM_W : cbo_pkg::RAD_W;

  logic [COORD_BITS:0]   dxl, dxr, dyb, dyt;
  logic [COORD_BITS-1:0] abs_x_next, abs_y_next;
  logic [COORD_BITS-1:0] abs_x, abs_y;
  logic [SQ_W-1:0]       sq_x, sq_y;
  logic [CMP_W-1:0]      sum;
  logic                  v1, v2, v3;
  logic                  hit;

  // Below-low test wins over above-high, which matters for inverted boxes.
  always_comb begin
    dxl = {box_l[COORD_BITS-1], box_l} - {cx[COORD_BITS-1], cx};
    dxr = {cx[COORD_BITS-1], cx} - {box_r[COORD_BITS-1], box_r};
    dyb = {box_b[COORD_BITS-1], box_b} - {cy[COORD_BITS-1], cy};
    dyt = {cy[COORD_BITS-1], cy} - {box_t[COORD_BITS-1], box_t};
    if (cx < box_l) begin
      abs_x_next = dxl[COORD_BITS-1:0];
    end else if (cx > box_r) begin
      abs_x_next = dxr[COORD_BITS-1:0];
    end else begin
      abs_x_next = '0;
    end
    if (cy < box_b) begin
      abs_y_next = dyb[COORD_BITS-1:0];
    end else if (cy > box_t) begin
      abs_y_next = dyt[COORD_BITS-1:0];
    end else begin
      abs_y_next = '0;
    end
  end

  assign sum = CMP_W'(sq_x) + CMP_W'(sq_y);

  always_ff @(posedge clk) begin
    abs_x <= abs_x_next;
    abs_y <= abs_y_next;
    sq_x  <= SQ_W'(abs_x) * SQ_W'(abs_x);
    sq_y  <= SQ_W'(abs_y) * SQ_W'(abs_y);
    hit   <= (sum <= CMP_W'(radius_sq));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  assign stat.valid = v3;
  assign stat.hit   = hit;
  assign stat.busy  = v1 | v2 | v3;

endmodule

>>> tb/circle_box_overlap_counter_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for circle_box_overlap_counter_core: directed and random add/check/clear
// traffic under several radius settings, scored against an in-bench table model.
// Depends on cbo_pkg and the core RTL.
module circle_box_overlap_counter_core_tb;

  localparam int         CW         = cbo_pkg::COORD_BITS_DEF;
  localparam int         CNT_W      = $clog2(cbo_pkg::ENTRIES_DEF + 1);
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  // no random stalls on either side inside this window
  localparam int         CALM_START = 4000;
  localparam int         CALM_END   = 7000;
  localparam int         PHASE_ITEMS = 150;

  typedef struct {
    logic [1:0]           kind;
    logic signed [CW-1:0] px, py, bl, br, bb, bt;
  } overlap_req_t;

  typedef struct {
    logic [CNT_W-1:0] hits;
    logic             acc;
    logic [CNT_W-1:0] fill;
  } overlap_resp_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_wr_en = 1'b0;
  logic [cbo_pkg::RAD_W-1:0]    cfg_wr_data = '0;
  logic                         in_valid = 1'b0;
  logic                         in_ready;
  logic [1:0]                   req_type = cbo_pkg::REQ_ADD;
  logic signed [CW-1:0]         point_x = '0;
  logic signed [CW-1:0]         point_y = '0;
  logic signed [CW-1:0]         box_left = '0;
  logic signed [CW-1:0]         box_right = '0;
  logic signed [CW-1:0]         box_bottom = '0;
  logic signed [CW-1:0]         box_top = '0;
  logic                         out_valid;
  logic                         out_ready = 1'b0;
  logic [CNT_W-1:0]             hit_count;
  logic                         accepted;
  logic [CNT_W-1:0]             stored_count;

  // table model
  logic signed [CW-1:0]         cell_x [cbo_pkg::ENTRIES_DEF];
  logic signed [CW-1:0]         cell_y [cbo_pkg::ENTRIES_DEF];
  int                           fill_level = 0;
  logic [cbo_pkg::RAD_W-1:0]    rad_sq = cbo_pkg::RADIUS_SQ_RESET;

  overlap_req_t  pending_reqs [$];
  overlap_resp_t expected_results [$];
  overlap_req_t  cur_req;
  int            error_count = 0;
  int            cycle_no = 0;
  int            items_queued = 0;

  circle_box_overlap_counter_core dut (
    .clk, .rst, .cfg_wr_en, .cfg_wr_data, .in_valid, .in_ready, .req_type,
    .point_x, .point_y, .box_left, .box_right, .box_bottom, .box_top,
    .out_valid, .out_ready, .hit_count, .accepted, .stored_count
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit take_break();
    return (cycle_no < CALM_START || cycle_no >= CALM_END) && ($urandom_range(0, 99) < 15);
  endfunction

  function automatic int rand_coord();
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  task automatic flag_error(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    if (error_count <= 50)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
  endtask

  // Applies one request to the table model and returns the response it should produce.
  function automatic overlap_resp_t predict_request(overlap_req_t r);
    overlap_resp_t res;
    int            cx, cy, qx, qy;
    longint        dx, dy;
    res.hits = '0;
    res.acc  = 1'b0;
    case (r.kind)
      cbo_pkg::REQ_ADD: begin
        if (fill_level < cbo_pkg::ENTRIES_DEF) begin
          cell_x[fill_level] = r.px;
          cell_y[fill_level] = r.py;
          fill_level++;
          res.acc = 1'b1;
        end
      end
      cbo_pkg::REQ_CHECK: begin
        for (int i = 0; i < fill_level; i++) begin
          cx = int'(cell_x[i]);
          cy = int'(cell_y[i]);
          // low bound wins on an inverted box
          qx = (cx < int'(r.bl)) ? int'(r.bl) : (cx > int'(r.br)) ? int'(r.br) : cx;
          qy = (cy < int'(r.bb)) ? int'(r.bb) : (cy > int'(r.bt)) ? int'(r.bt) : cy;
          dx = longint'(cx - qx);
          dy = longint'(cy - qy);
          if (dx * dx + dy * dy <= longint'({31'b0, rad_sq}))
            res.hits = res.hits + 1'b1;
        end
        res.acc = 1'b1;
      end
      cbo_pkg::REQ_CLEAR: begin
        fill_level = 0;
        res.acc = 1'b1;
      end
      default: ;
    endcase
    res.fill = CNT_W'(fill_level);
    return res;
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready)
        expected_results.push_back(predict_request(cur_req));
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && !take_break()) begin
          cur_req = pending_reqs.pop_front();
          req_type   <= cur_req.kind;
          point_x    <= cur_req.px;
          point_y    <= cur_req.py;
          box_left   <= cur_req.bl;
          box_right  <= cur_req.br;
          box_bottom <= cur_req.bb;
          box_top    <= cur_req.bt;
          in_valid   <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // response monitor
  always @(posedge clk) begin
    overlap_resp_t want;
    cycle_no <= cycle_no + 1;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          flag_error("transaction with nothing outstanding, stored_count", stored_count, 0);
        end else begin
          want = expected_results.pop_front();
          if (hit_count !== want.hits) flag_error("hit_count", hit_count, want.hits);
          if (accepted !== want.acc) flag_error("accepted", accepted, want.acc);
          if (stored_count !== want.fill) flag_error("stored_count", stored_count, want.fill);
        end
      end
      out_ready <= !take_break();
    end
  end

  task automatic push_req(logic [1:0] kind, int px, int py, int bl, int br, int bb, int bt);
    overlap_req_t r;
    r.kind = kind;
    r.px = CW'(px);
    r.py = CW'(py);
    r.bl = CW'(bl);
    r.br = CW'(br);
    r.bb = CW'(bb);
    r.bt = CW'(bt);
    pending_reqs.push_back(r);
    items_queued++;
  endtask

  task automatic push_add(int px, int py);
    push_req(cbo_pkg::REQ_ADD, px, py, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic push_check(int bl, int br, int bb, int bt);
    push_req(cbo_pkg::REQ_CHECK, rand_coord(), rand_coord(), bl, br, bb, bt);
  endtask

  // Box checks mostly land near the cluster so that hits and near misses both occur.
  task automatic push_cluster_check(int cx0, int cy0);
    int pick, x0, y0;
    pick = $urandom_range(0, 9);
    x0 = cx0 + int'($urandom_range(0, 800)) - 400;
    y0 = cy0 + int'($urandom_range(0, 800)) - 400;
    if (pick < 7)
      push_check(x0 - int'($urandom_range(0, 300)), x0 + int'($urandom_range(0, 300)),
                 y0 - int'($urandom_range(0, 300)), y0 + int'($urandom_range(0, 300)));
    else if (pick == 7)
      push_check(x0 + int'($urandom_range(1, 300)), x0 - int'($urandom_range(0, 300)),
                 y0 + int'($urandom_range(0, 300)), y0 - int'($urandom_range(0, 300)));
    else if (pick == 8)
      push_check(rand_coord(), rand_coord(), rand_coord(), rand_coord());
    else
      push_check(x0, x0, y0, y0);
  endtask

  task automatic queue_random_phase(int n);
    int stop_at, cx0, cy0, n_add, n_chk;
    stop_at = items_queued + n;
    while (items_queued < stop_at) begin
      if ($urandom_range(0, 99) < 80) begin
        cx0 = int'($urandom_range(0, 60000)) - 30000;
        cy0 = int'($urandom_range(0, 60000)) - 30000;
        if ($urandom_range(0, 3) != 0)
          push_req(cbo_pkg::REQ_CLEAR, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                   rand_coord(), rand_coord());
        n_add = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 8);
        repeat (n_add) begin
          if ($urandom_range(0, 9) != 0)
            push_add(cx0 + int'($urandom_range(0, 1000)) - 500,
                     cy0 + int'($urandom_range(0, 1000)) - 500);
          else
            push_add(rand_coord(), rand_coord());
        end
        n_chk = $urandom_range(1, 4);
        repeat (n_chk) push_cluster_check(cx0, cy0);
      end else begin
        push_req(2'($urandom_range(0, 3)), rand_coord(), rand_coord(), rand_coord(),
                 rand_coord(), rand_coord(), rand_coord());
      end
    end
  endtask

  // sampled at the falling edge so the driver's updates of the last rising edge are settled
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0);
    // a check sweeps the whole ring and drains the distance unit; leave margin
    repeat (cbo_pkg::ENTRIES_DEF + 8) @(posedge clk);
  endtask

  task automatic write_radius(logic [cbo_pkg::RAD_W-1:0] v);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    rad_sq = v;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: reset radius of 10000
    push_check(-32768, 32767, -32768, 32767);    // empty table
    push_add(-32768, -32768);
    push_add(32767, 32767);
    push_add(0, 0);
    push_add(100, 0);                            // exactly on the radius
    push_add(60, 80);                            // exactly on the radius
    push_add(60, 81);                            // just outside
    push_check(0, 0, 0, 0);
    push_check(-32768, 32767, -32768, 32767);
    push_check(32767, 32767, -32768, -32768);
    push_check(10, -10, 10, -10);                // inverted box
    push_req(REQ_UNUSED, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord());
    repeat (10) push_add(rand_coord(), rand_coord());
    push_add(5, 5);                              // table full, dropped
    push_check(-200, 200, -200, 200);
    push_req(cbo_pkg::REQ_CLEAR, rand_coord(), rand_coord(), rand_coord(), rand_coord(),
             rand_coord(), rand_coord());
    push_check(-32768, 32767, -32768, 32767);

    write_radius({cbo_pkg::RAD_W{1'b1}});
    queue_random_phase(PHASE_ITEMS);
    write_radius('0);
    queue_random_phase(PHASE_ITEMS);
    write_radius(cbo_pkg::RAD_W'($urandom_range(2, 2000000)));
    queue_random_phase(PHASE_ITEMS);
    write_radius(cbo_pkg::RAD_W'(1));
    queue_random_phase(PHASE_ITEMS);
    write_radius({1'($urandom_range(0, 1)), 32'($urandom)});
    queue_random_phase(PHASE_ITEMS);
    write_radius(cbo_pkg::RADIUS_SQ_RESET);
    queue_random_phase(PHASE_ITEMS);

    wait_drained();
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
